[hw/rtl/rbis_pkg.sv]
// Shared types and constants of the RGBA bilinear image scaler.
package rbis_pkg;

  localparam int DEF_MAX_SIDE      = 128;
  localparam int DEF_FRACTION_BITS = 8;

  localparam int SIDE_W  = 8;
  localparam int PCT_W   = 10;
  localparam int POS_W   = 10;
  localparam int CH_W    = 8;
  localparam int PIX_W   = 32;
  localparam int NUM_W   = POS_W + SIDE_W;
  localparam int PROD_W  = SIDE_W + PCT_W;
  localparam int NEW_W   = 12;
  localparam int CFG_W   = 10;
  localparam int IDX_W   = 3;
  localparam int DIV_RADIX_BITS = 4;

  // floor(x / 100) == (x * PERCENT_RECIP) >> RECIP_SHIFT for x < 2**30
  localparam int RECIP_W     = 26;
  localparam int RECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0] PERCENT_RECIP = 26'd42949673;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [SIDE_W-1:0] RST_SIDE  = 8'd128;
  localparam logic [PCT_W-1:0]  RST_SCALE = 10'd100;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 3'd0,
    CFG_SOURCE_HEIGHT = 3'd1,
    CFG_SCALE_X       = 3'd2,
    CFG_SCALE_Y       = 3'd3,
    CFG_NEAREST       = 3'd4,
    CFG_ALPHA_CUT     = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[hw/rtl/rbis_divider.sv]
// Iterative restoring divider, four quotient bits per cycle.
module rbis_divider #(
  parameter int FRACTION_BITS = rbis_pkg::DEF_FRACTION_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rbis_pkg::NUM_W-1:0]     num,
  input  logic [rbis_pkg::NEW_W-1:0]     den,
  output rbis_pkg::div_status_t          stat,
  output logic [rbis_pkg::SIDE_W+FRACTION_BITS-1:0] quot
);

  localparam int QB  = rbis_pkg::SIDE_W + FRACTION_BITS;
  localparam int RB  = rbis_pkg::DIV_RADIX_BITS;
  localparam int ST  = (QB + RB - 1) / RB;
  localparam int QP  = ST * RB;
  localparam int PAD = QP - QB;
  localparam int CW  = $clog2(ST + 1);
  localparam int NW  = rbis_pkg::NEW_W;

  logic [CW-1:0] cnt;
  logic [NW-1:0] rem;
  logic [QP-1:0] nsh;
  logic [QP-1:0] q;

  logic [NW-1:0] rem_next;
  logic [QP-1:0] nsh_next;
  logic [QP-1:0] q_next;
  logic [NW:0]   trial;

  always_comb begin
    rem_next = rem;
    nsh_next = nsh;
    q_next   = q;
    trial    = '0;
    for (int i = 0; i < RB; i++) begin
      trial    = {rem_next, nsh_next[QP-1]};
      nsh_next = {nsh_next[QP-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem_next = NW'(trial - {1'b0, den});
        q_next   = {q_next[QP-2:0], 1'b1};
      end else begin
        rem_next = trial[NW-1:0];
        q_next   = {q_next[QP-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(ST);
    end else if (cnt != '0) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= NW'(num[rbis_pkg::NUM_W-1:rbis_pkg::SIDE_W]);
      nsh <= QP'(num[rbis_pkg::SIDE_W-1:0]) << (QP - rbis_pkg::SIDE_W);
      q   <= '0;
    end else if (cnt != '0) begin
      rem <= rem_next;
      nsh <= nsh_next;
      q   <= q_next;
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = (cnt <= CW'(1));
  assign quot      = (cnt != '0) ? q_next[QP-1:PAD] : q[QP-1:PAD];

endmodule

[hw/rtl/rgba_bilinear_image_scaler.sv]
// RGBA image scaler top level: pixel store, divider front end, blend pipe, result queue.
// Load words write one source pixel into a single-port store of MAX_SIDE x MAX_SIDE words
// and move at one word per cycle unless a configuration stall or a busy back end holds the
// input. A request word finds its source position with two dividers that produce four
// quotient bits per cycle; a bilinear request then makes four reads of the single
// pixel-store port, one per neighbor, while nearest and outside requests make one. The
// front end can take the next request while the back end still works on the last one.
// After any configuration write the input stalls while the destination size is
// recomputed. Up to four results queue at the output.
module rgba_bilinear_image_scaler #(
  parameter int MAX_SIDE      = rbis_pkg::DEF_MAX_SIDE,
  parameter int FRACTION_BITS = rbis_pkg::DEF_FRACTION_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [55:0]                  s_tdata,  // column, row, red_in, green_in, blue_in, alpha_in
  input  logic                         s_tuser,  // operation
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [31:0]                  m_tdata,  // red_out, green_out, blue_out, alpha_out
  output logic                         m_tuser,  // inside_res
  input  logic                         cfg_we,
  input  logic [rbis_pkg::IDX_W-1:0]   cfg_index,
  input  logic [rbis_pkg::CFG_W-1:0]   cfg_data
);

  localparam int FB    = FRACTION_BITS;
  localparam int QB    = rbis_pkg::SIDE_W + FB;
  localparam int IW    = $clog2(MAX_SIDE);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int ADW   = $clog2(DEPTH);
  localparam int WW    = 2 * FB + 1;
  localparam int AW    = 2 * FB + rbis_pkg::CH_W;
  localparam int SW    = rbis_pkg::SIDE_W;
  localparam int NW    = rbis_pkg::NEW_W;
  localparam int PW    = rbis_pkg::POS_W;
  localparam int CHW   = rbis_pkg::CH_W;
  localparam int FD    = rbis_pkg::FIFO_DEPTH;
  localparam int FPW   = rbis_pkg::FIFO_PW;
  localparam int FCW   = rbis_pkg::FIFO_CW;
  localparam logic [FB:0] ONE = (FB + 1)'(1) << FB;

  // configuration
  logic [SW-1:0]             source_width, source_height;
  logic [rbis_pkg::PCT_W-1:0] scale_x_percent, scale_y_percent;
  logic                      nearest_mode;
  logic [CHW-1:0]            alpha_cut;
  logic [1:0]                cfg_cnt;
  logic [rbis_pkg::PROD_W-1:0] prod_x, prod_y;
  logic [NW-1:0]             newx, newy;
  logic [SW-1:0]             w, h;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width    <= rbis_pkg::RST_SIDE;
      source_height   <= rbis_pkg::RST_SIDE;
      scale_x_percent <= rbis_pkg::RST_SCALE;
      scale_y_percent <= rbis_pkg::RST_SCALE;
      nearest_mode    <= 1'b0;
      alpha_cut       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rbis_pkg::CFG_SOURCE_WIDTH:  source_width    <= cfg_data[SW-1:0];
        rbis_pkg::CFG_SOURCE_HEIGHT: source_height   <= cfg_data[SW-1:0];
        rbis_pkg::CFG_SCALE_X:       scale_x_percent <= cfg_data;
        rbis_pkg::CFG_SCALE_Y:       scale_y_percent <= cfg_data;
        rbis_pkg::CFG_NEAREST:       nearest_mode    <= cfg_data[0];
        rbis_pkg::CFG_ALPHA_CUT:     alpha_cut       <= cfg_data[CHW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w = (32'(source_width) > MAX_SIDE) ? SW'(MAX_SIDE) : source_width;
    h = (32'(source_height) > MAX_SIDE) ? SW'(MAX_SIDE) : source_height;
  end

  // destination size, two register stages behind the configuration
  always_ff @(posedge clk) begin
    prod_x <= rbis_pkg::PROD_W'(w) * rbis_pkg::PROD_W'(scale_x_percent);
    prod_y <= rbis_pkg::PROD_W'(h) * rbis_pkg::PROD_W'(scale_y_percent);
    newx   <= NW'((44'(prod_x) * 44'(rbis_pkg::PERCENT_RECIP)) >> rbis_pkg::RECIP_SHIFT);
    newy   <= NW'((44'(prod_y) * 44'(rbis_pkg::PERCENT_RECIP)) >> rbis_pkg::RECIP_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      cfg_cnt <= 2'd2;
    end else if (cfg_cnt != 2'd0) begin
      cfg_cnt <= cfg_cnt - 2'd1;
    end
  end

  // input word fields
  logic [PW-1:0]  in_col, in_row;
  logic [31:0]    in_pix;
  logic           in_op, in_ok, accept, start;

  assign in_col = s_tdata[9:0];
  assign in_row = s_tdata[19:10];
  assign in_pix = s_tdata[51:20];
  assign in_op  = s_tuser;

  always_comb begin
    if (in_op == rbis_pkg::OP_LOAD) begin
      in_ok = (in_col < PW'(w)) && (in_row < PW'(h));
    end else begin
      in_ok = (newx != '0) && (newy != '0) &&
              (NW'(in_col) < newx) && (NW'(in_row) < newy);
    end
  end

  assign accept = s_tvalid && s_tready;
  assign start  = accept && (in_op == rbis_pkg::OP_REQUEST) && in_ok;

  // front end
  logic                 f_valid, f_op, f_ok;
  logic [PW-1:0]        f_col, f_row;
  logic [31:0]          f_pix;
  rbis_pkg::div_status_t div_x_stat, div_y_stat;
  logic [QB-1:0]        quot_x, quot_y;

  rbis_divider #(.FRACTION_BITS(FB)) u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .num   (rbis_pkg::NUM_W'(in_col) * rbis_pkg::NUM_W'(w)),
    .den   (newx),
    .stat  (div_x_stat),
    .quot  (quot_x)
  );

  rbis_divider #(.FRACTION_BITS(FB)) u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .num   (rbis_pkg::NUM_W'(in_row) * rbis_pkg::NUM_W'(h)),
    .den   (newy),
    .stat  (div_y_stat),
    .quot  (quot_y)
  );

  // back end job
  logic            b_valid, b_load, b_ok, b_one;
  logic [1:0]      b_phase;
  logic [IW-1:0]   b_x0, b_x1, b_y0, b_y1;
  logic [FB-1:0]   b_dx, b_dy;
  logic [31:0]     b_pix;
  logic            b_last, job_free, credit_ok, f_done, hand, push, pop;
  logic [FCW-1:0]  pend, fifo_cnt;

  assign b_last    = b_one || (b_phase == 2'd3);
  assign job_free  = !b_valid || b_last;
  assign credit_ok = ((FCW + 1)'(pend) + (FCW + 1)'(fifo_cnt)) < (FCW + 1)'(FD);
  assign f_done    = (f_op == rbis_pkg::OP_LOAD) || !f_ok ||
                     (div_x_stat.done && div_y_stat.done);
  assign hand      = f_valid && f_done && job_free &&
                     ((f_op == rbis_pkg::OP_LOAD) || credit_ok);
  assign s_tready  = (cfg_cnt == 2'd0) && (!f_valid || hand);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (hand) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_op  <= in_op;
      f_ok  <= in_ok;
      f_col <= in_col;
      f_row <= in_row;
      f_pix <= in_pix;
    end
  end

  logic [SW-1:0] qx0, qy0, qx1, qy1;

  always_comb begin
    qx0 = quot_x[QB-1:FB];
    qy0 = quot_y[QB-1:FB];
    qx1 = ({1'b0, qx0} + 9'd1 < {1'b0, w}) ? qx0 + SW'(1) : w - SW'(1);
    qy1 = ({1'b0, qy0} + 9'd1 < {1'b0, h}) ? qy0 + SW'(1) : h - SW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_phase <= 2'd0;
    end else if (job_free) begin
      b_valid <= hand;
      b_phase <= 2'd0;
    end else begin
      b_phase <= b_phase + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (hand) begin
      b_load <= (f_op == rbis_pkg::OP_LOAD);
      b_ok   <= f_ok;
      b_pix  <= f_pix;
      if (f_op == rbis_pkg::OP_LOAD) begin
        b_one <= 1'b1;
        b_x0  <= IW'(f_col);
        b_y0  <= IW'(f_row);
        b_x1  <= IW'(f_col);
        b_y1  <= IW'(f_row);
        b_dx  <= '0;
        b_dy  <= '0;
      end else if (!f_ok) begin
        b_one <= 1'b1;
        b_x0  <= '0;
        b_y0  <= '0;
        b_x1  <= '0;
        b_y1  <= '0;
        b_dx  <= '0;
        b_dy  <= '0;
      end else begin
        b_one <= nearest_mode;
        b_x0  <= IW'(qx0);
        b_y0  <= IW'(qy0);
        b_x1  <= IW'(qx1);
        b_y1  <= IW'(qy1);
        b_dx  <= nearest_mode ? '0 : quot_x[FB-1:0];
        b_dy  <= nearest_mode ? '0 : quot_y[FB-1:0];
      end
    end
  end

  // pixel store
  logic [31:0]    mem [DEPTH];
  logic [31:0]    rdata;
  logic [ADW-1:0] addr;
  logic [IW-1:0]  a_col, a_row;
  logic           mem_we, mem_re;

  assign a_col  = b_phase[0] ? b_x1 : b_x0;
  assign a_row  = b_phase[1] ? b_y1 : b_y0;
  assign addr   = ADW'(a_row) * ADW'(MAX_SIDE) + ADW'(a_col);
  assign mem_we = b_valid && b_load && b_ok;
  assign mem_re = b_valid && !b_load;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= b_pix;
    end else if (mem_re) begin
      rdata <= mem[addr];
    end
  end

  // blend pipe: read, weight product, accumulate
  logic            r_v, r_first, r_last, r_ok;
  logic [WW-1:0]   r_w;
  logic [FB:0]     wx, wy;
  logic            p_v, p_first, p_last, p_ok;
  logic [AW-1:0]   p_prod [4];
  logic [AW-1:0]   acc [4];
  logic [AW-1:0]   acc_next [4];
  logic [CHW-1:0]  res_ch [4];
  logic [CHW-1:0]  res_alpha;

  assign wx = b_phase[0] ? {1'b0, b_dx} : ONE - {1'b0, b_dx};
  assign wy = b_phase[1] ? {1'b0, b_dy} : ONE - {1'b0, b_dy};

  always_ff @(posedge clk) begin
    if (rst) begin
      r_v <= 1'b0;
      p_v <= 1'b0;
    end else begin
      r_v <= mem_re;
      p_v <= r_v;
    end
  end

  always_ff @(posedge clk) begin
    r_first <= (b_phase == 2'd0);
    r_last  <= b_last;
    r_ok    <= b_ok;
    r_w     <= WW'((2 * FB + 2)'(wx) * (2 * FB + 2)'(wy));
    p_first <= r_first;
    p_last  <= r_last;
    p_ok    <= r_ok;
    for (int c = 0; c < 4; c++) begin
      p_prod[c] <= r_ok ? AW'(AW'(rdata[CHW*c +: CHW]) * AW'(r_w)) : '0;
    end
    if (p_v) begin
      for (int c = 0; c < 4; c++) begin
        acc[c] <= acc_next[c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      acc_next[c] = (p_first ? '0 : acc[c]) + p_prod[c];
      res_ch[c]   = acc_next[c][2*FB +: CHW];
    end
    res_alpha = (res_ch[3] > alpha_cut) ? res_ch[3] - alpha_cut : '0;
  end

  assign push = p_v && p_last;

  // result queue
  logic [32:0]    fifo [FD];
  logic [FPW-1:0] wr_ptr, rd_ptr;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (fifo_cnt != '0);
  assign m_tdata  = fifo[rd_ptr][31:0];
  assign m_tuser  = fifo[rd_ptr][32];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= {p_ok, res_alpha, res_ch[2], res_ch[1], res_ch[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
      pend     <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FPW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FPW'(1);
      end
      fifo_cnt <= fifo_cnt + FCW'(push) - FCW'(pop);
      pend     <= pend + FCW'(hand && (f_op == rbis_pkg::OP_REQUEST)) - FCW'(push);
    end
  end

  a_credit: assert property (@(posedge clk) disable iff (rst)
    (32'(pend) + 32'(fifo_cnt)) <= FD)
    else $error("result credit overrun");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> ((32'(fifo_cnt) < FD) || pop))
    else $error("result queue overflow");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (hand && f_op == rbis_pkg::OP_REQUEST && f_ok) |-> (div_x_stat.done && div_y_stat.done))
    else $error("request left front end before divide finished");

  a_push_pending: assert property (@(posedge clk) disable iff (rst)
    push |-> (pend != '0))
    else $error("result with no pending request");

endmodule
